// ===== hdl/swprs_pkg.sv =====
// Package for the sorted word prefix range search block.
// Transaction payload types, action codes, controller/datapath command and status structs.
// No dependencies; every other file but swprs_chan_if uses it by scoped names.
package swprs_pkg;

    localparam int WORD_SLOTS_DEF   = 4096;
    localparam int MAX_WORD_LEN_DEF = 32;

    // Port field widths
    localparam int IDX_W  = 12;
    localparam int POS_W  = 5;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 6;
    // Search bounds carry one extra bit so that range_high + 1 fits
    localparam int SIDX_W = IDX_W + 1;

    localparam logic [1:0] ACT_WR_CHAR = 2'd0;
    localparam logic [1:0] ACT_WR_LEN  = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  word_index;
        logic [POS_W-1:0]  char_pos;
        logic [CHAR_W-1:0] char_value;
        logic [LEN_W-1:0]  word_length;
        logic [IDX_W-1:0]  range_low;
        logic [IDX_W-1:0]  range_high;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_low;
        logic [IDX_W-1:0] match_high;
    } rsp_t;

    typedef struct packed {
        logic wr_char;   // store one character
        logic wr_len;    // store one word length
        logic init;      // latch query, start lower-bound search
        logic step;      // one probe update of the search window
        logic strict;    // upper-bound compare (key <= letter)
        logic start_ub;  // keep lower bound, restart window for upper bound
        logic set_fail;  // result: not found
        logic set_hit;   // result: found, bounds from search
        logic publish;   // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic done;      // search window empty
        logic at_end;    // lower bound ran past the range
        logic key_eq;    // probed key equals the letter
        logic out_free;  // output register can take a result
    } sts_t;

endpackage

// ===== hdl/swprs_chan_if.sv =====
// Valid/ready channel interface carrying one payload struct per transaction.
// Payload type is a parameter; used with swprs_pkg::req_t and swprs_pkg::rsp_t.
interface swprs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sorted_word_prefix_range_search_top.sv =====
// Sorted word list with prefix range search: top level.
// Joins swprs_ctrl and swprs_datapath; channels are swprs_chan_if, types from swprs_pkg.
//
// Load transactions (write character, write word length) are accepted back to back. A
// query runs two binary searches over the clamped range, each probe being one read of
// the word memories followed by one compare, plus setup and result hand-off. The single
// read port of the word memories sets the pace of the probes. A query that misses stops
// after the first search. Memories are not cleared; a finished result waits in an output
// register while loads continue to be accepted.
module sorted_word_prefix_range_search_top #(
    parameter int WORD_SLOTS   = swprs_pkg::WORD_SLOTS_DEF,
    parameter int MAX_WORD_LEN = swprs_pkg::MAX_WORD_LEN_DEF
) (
    input logic   clk,
    input logic   rst_n,
    swprs_chan_if.sink   req,
    swprs_chan_if.source rsp
);

    swprs_pkg::cmd_t cmd;
    swprs_pkg::sts_t sts;
    swprs_pkg::req_t req_data;
    swprs_pkg::rsp_t rsp_data;
    logic            req_ready;
    logic            rsp_valid;

    assign req_data  = req.data;
    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    swprs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req_data.action),
        .req_ready  (req_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    swprs_datapath #(
        .WORD_SLOTS   (WORD_SLOTS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_data  (req_data),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .rsp_ready (rsp.ready)
    );

endmodule

// ===== hdl/swprs_datapath.sv =====
// Datapath: word character and length memories, binary search window, output register.
// Driven by swprs_ctrl through swprs_pkg::cmd_t; reports swprs_pkg::sts_t.
module swprs_datapath #(
    parameter int WORD_SLOTS   = swprs_pkg::WORD_SLOTS_DEF,
    parameter int MAX_WORD_LEN = swprs_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swprs_pkg::cmd_t      cmd,
    input  swprs_pkg::req_t      req_data,
    output swprs_pkg::sts_t      sts,
    output logic                 rsp_valid,
    output swprs_pkg::rsp_t      rsp_data,
    input  logic                 rsp_ready
);

    localparam int SW   = swprs_pkg::SIDX_W;
    localparam int IW   = swprs_pkg::IDX_W;
    localparam int WW   = $clog2(WORD_SLOTS);
    localparam int CA_W = $clog2(WORD_SLOTS * MAX_WORD_LEN);
    localparam int LW   = $clog2(MAX_WORD_LEN + 1);

    logic [7:0]    char_mem [WORD_SLOTS * MAX_WORD_LEN];
    logic [LW-1:0] len_mem  [WORD_SLOTS];

    logic [SW-1:0] lo_reg, hi1_reg, a_reg, b_reg, m_reg, lb_reg;
    logic [SW-1:0] a_next, b_next;
    logic [swprs_pkg::POS_W-1:0]  pos_reg;
    logic [swprs_pkg::CHAR_W-1:0] letter_reg;
    logic                         pos_ok_reg;
    logic [7:0]                   char_rd;
    logic [LW-1:0]                len_rd;

    logic          res_found_reg;
    logic [IW-1:0] res_lo_reg, res_hi_reg;
    logic          out_valid_reg;
    swprs_pkg::rsp_t out_data_reg;

    logic          widx_ok, wpos_ok, qpos_ok;
    logic [IW-1:0] hi_clamp;
    logic [SW-1:0] q_lo, q_hi1;
    logic [CA_W-1:0] wr_addr, rd_addr;
    logic [LW-1:0] len_sat;
    logic          kvalid, key_lt, key_le, below;

    function automatic logic [SW-1:0] mid(input logic [SW-1:0] x, input logic [SW-1:0] y);
        logic [SW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[SW:1];
    endfunction

    // Load path
    assign widx_ok = 32'(req_data.word_index) < WORD_SLOTS;
    assign wpos_ok = 32'(req_data.char_pos) < MAX_WORD_LEN;
    assign wr_addr = CA_W'(req_data.word_index) * CA_W'(MAX_WORD_LEN)
                   + CA_W'(req_data.char_pos);
    assign len_sat = (32'(req_data.word_length) > MAX_WORD_LEN) ? LW'(MAX_WORD_LEN)
                                                                : LW'(req_data.word_length);

    // Query setup
    assign hi_clamp = (32'(req_data.range_high) >= WORD_SLOTS) ? IW'(WORD_SLOTS - 1)
                                                               : req_data.range_high;
    assign q_lo     = {1'b0, req_data.range_low};
    assign q_hi1    = {1'b0, hi_clamp} + SW'(1);
    assign qpos_ok  = 32'(req_data.char_pos) < MAX_WORD_LEN;

    // Probe address; position masked when past the word size so the address stays in range
    assign rd_addr = CA_W'(m_reg) * CA_W'(MAX_WORD_LEN)
                   + (pos_ok_reg ? CA_W'(pos_reg) : CA_W'(0));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_char && widx_ok && wpos_ok)
        begin
            char_mem[wr_addr] <= req_data.char_value;
        end
        char_rd <= char_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_len && widx_ok)
        begin
            len_mem[WW'(req_data.word_index)] <= len_sat;
        end
        len_rd <= len_mem[WW'(m_reg)];
    end

    // Short words and positions past the word size sort below every letter
    assign kvalid = pos_ok_reg && (32'(len_rd) > 32'(pos_reg));
    assign key_lt = !kvalid || (char_rd < letter_reg);
    assign key_le = !kvalid || (char_rd <= letter_reg);
    assign below  = cmd.strict ? key_le : key_lt;

    assign a_next = below ? (m_reg + SW'(1)) : a_reg;
    assign b_next = below ? b_reg : m_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            lo_reg     <= q_lo;
            hi1_reg    <= q_hi1;
            a_reg      <= q_lo;
            b_reg      <= q_hi1;
            m_reg      <= mid(q_lo, q_hi1);
            pos_reg    <= req_data.char_pos;
            letter_reg <= req_data.char_value;
            pos_ok_reg <= qpos_ok;
        end
        else if (cmd.step)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            m_reg <= mid(a_next, b_next);
        end
        else if (cmd.start_ub)
        begin
            lb_reg <= a_reg;
            a_reg  <= lo_reg;
            b_reg  <= hi1_reg;
            m_reg  <= mid(lo_reg, hi1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_fail)
        begin
            res_found_reg <= 1'b0;
            res_lo_reg    <= '0;
            res_hi_reg    <= '0;
        end
        else if (cmd.set_hit)
        begin
            res_found_reg <= 1'b1;
            res_lo_reg    <= lb_reg[IW-1:0];
            res_hi_reg    <= (a_reg > lb_reg + SW'(1)) ? IW'(a_reg - SW'(1)) : lb_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_data_reg.found      <= res_found_reg;
            out_data_reg.match_low  <= res_lo_reg;
            out_data_reg.match_high <= res_hi_reg;
        end
    end

    // An empty range starts with a past hi+1, so compare rather than test equality
    assign sts.done     = !(a_reg < b_reg);
    assign sts.at_end   = !(a_reg < hi1_reg);
    assign sts.key_eq   = kvalid && (char_rd == letter_reg);
    assign sts.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

// ===== hdl/swprs_ctrl.sv =====
// Controller state machine: sequences loads, the two binary searches and result hand-off.
// Uses swprs_pkg command/status structs; pairs with swprs_datapath.
module swprs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_action,
    output logic             req_ready,
    input  swprs_pkg::sts_t  sts,
    output swprs_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LRD  = 7'b0000010,  // lower bound: memory read of the probe
        S_LCMP = 7'b0000100,  // lower bound: compare and narrow
        S_VCMP = 7'b0001000,  // check key at the lower bound
        S_URD  = 7'b0010000,
        S_UCMP = 7'b0100000,
        S_PUB  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.wr_char = accept && (req_action == swprs_pkg::ACT_WR_CHAR);
                cmd.wr_len  = accept && (req_action == swprs_pkg::ACT_WR_LEN);
                if (accept && (req_action == swprs_pkg::ACT_QUERY))
                begin
                    cmd.init   = 1'b1;
                    state_next = S_LRD;
                end
            end
            S_LRD:
            begin
                if (!sts.done)
                begin
                    state_next = S_LCMP;
                end
                else if (sts.at_end)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_PUB;
                end
                else
                begin
                    state_next = S_VCMP;
                end
            end
            S_LCMP:
            begin
                cmd.step   = 1'b1;
                state_next = S_LRD;
            end
            S_VCMP:
            begin
                if (sts.key_eq)
                begin
                    cmd.start_ub = 1'b1;
                    state_next   = S_URD;
                end
                else
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_PUB;
                end
            end
            S_URD:
            begin
                if (sts.done)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_PUB;
                end
                else
                begin
                    state_next = S_UCMP;
                end
            end
            S_UCMP:
            begin
                cmd.step   = 1'b1;
                cmd.strict = 1'b1;
                state_next = S_URD;
            end
            S_PUB:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/swprs_checker.sv =====
// Port-level checker for the prefix range search top level, with its bind statement.
// Uses swprs_pkg action codes; watches only the top-level channels.
module swprs_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic [1:0]              req_action,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    rsp_found,
    input logic [swprs_pkg::IDX_W-1:0] rsp_match_low,
    input logic [swprs_pkg::IDX_W-1:0] rsp_match_high
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_match_low) && $stable(rsp_match_high))
        else $error("result changed while stalled");

    // Only one query in flight
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == swprs_pkg::ACT_QUERY) |=> !req_ready)
        else $error("input ready right after a query");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> (rsp_match_low == '0) && (rsp_match_high == '0))
        else $error("not-found result carries bounds");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_match_low <= rsp_match_high)
        else $error("match bounds out of order");

endmodule

bind sorted_word_prefix_range_search_top swprs_checker u_swprs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_action     (req.data.action),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.data.found),
    .rsp_match_low  (rsp.data.match_low),
    .rsp_match_high (rsp.data.match_high)
);
